### rtl/pfc_pkg.sv
// Package with the shared types, constants and CRC function of the packet framer.
`default_nettype none

package pfc_pkg;

    localparam int PREAMBLE_LENGTH = 8;
    localparam int MAX_RESULTS     = 16;

    // Preamble bytes actually sent: the burst of one input stays within its result budget.
    localparam int PRE_COUNT = (PREAMBLE_LENGTH > MAX_RESULTS - 8) ? (MAX_RESULTS - 8)
                                                                   : PREAMBLE_LENGTH;
    localparam int PRE_CNT_W = $clog2(PRE_COUNT + 1);

    localparam logic [7:0]  PREAMBLE_BYTE = 8'd10;
    localparam logic [7:0]  HEADER_ZERO   = 8'd0;
    localparam logic [31:0] CRC_POLY      = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT      = 32'hFFFFFFFF;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [7:0] frame_length;
        logic       start;
        logic       last;
    } pfc_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } pfc_fifo_status_t;

    typedef enum logic [3:0] {
        PH_HEAD,
        PH_PRE,
        PH_LEN,
        PH_ZERO1,
        PH_ZERO2,
        PH_DATA,
        PH_CRC3,
        PH_CRC2,
        PH_CRC1,
        PH_CRC0
    } pfc_phase_t;

    // Reflected CRC-32 update over one byte, one bit per step.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] data);
        logic [31:0] crc;
        crc = crc_in ^ {24'd0, data};
        for (int b = 0; b < 8; b++)
        begin
            if (crc[0])
                crc = (crc >> 1) ^ CRC_POLY;
            else
                crc = crc >> 1;
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

### rtl/pfc_in_if.sv
// Interface of the payload input channel.
`default_nettype none

interface pfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic [7:0] frame_length;
    logic       last_byte;

    modport source (output valid, output payload_byte, output frame_length,
                    output last_byte, input ready);
    modport sink   (input valid, input payload_byte, input frame_length,
                    input last_byte, output ready);
endinterface

`default_nettype wire

### rtl/pfc_out_if.sv
// Interface of the framed byte output channel.
`default_nettype none

interface pfc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       end_of_frame;
    logic       end_of_burst;

    modport source (output valid, output out_byte, output end_of_frame,
                    output end_of_burst, input ready);
    modport sink   (input valid, input out_byte, input end_of_frame,
                    input end_of_burst, output ready);
endinterface

`default_nettype wire

### rtl/packet_framer_crc32.sv
// Top level of the packet framer with CRC-32 trailer.
`default_nettype none

// Each accepted payload beat produces one output beat per cycle while the
// receiver is ready: a beat that opens a frame produces PRE_COUNT preamble
// bytes, three header bytes and the payload byte, a beat marked last adds four
// CRC bytes (most significant first), and a middle beat produces just its own
// byte. Input is taken at one beat per cycle while the four-entry queue between
// front and back has room; the sustained rate is set by the back end's single
// output byte per cycle. A frame of N payload bytes gives PRE_COUNT + N + 7 bytes.
module packet_framer_crc32
    import pfc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    pfc_in_if.sink    in_ch,
    pfc_out_if.source out_ch
);

    pfc_fifo_status_t fifo_status;
    pfc_item_t        push_item;
    pfc_item_t        head_item;
    logic             push;
    logic             pop;

    pfc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .fifo_status (fifo_status),
        .push        (push),
        .push_item   (push_item)
    );

    pfc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .status    (fifo_status)
    );

    pfc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_item   (head_item),
        .fifo_status (fifo_status),
        .pop         (pop),
        .out_ch      (out_ch)
    );

    // The last CRC byte always closes the burst of the beat that caused it.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.end_of_frame |-> out_ch.end_of_burst)
        else $error("end_of_frame without end_of_burst");

    // An accepted beat is held in the queue until the back end has used it.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> !fifo_status.empty)
        else $error("accepted beat missing from queue");

    // The back end never retires an entry from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !fifo_status.empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

### rtl/pfc_fifo.sv
// Short queue of classified payload beats between the front and the back.
`default_nettype none

module pfc_fifo
    import pfc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire pfc_item_t        push_item,
    input  wire logic             pop,
    output pfc_item_t             head_item,
    output pfc_fifo_status_t      status
);

    pfc_item_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   count_reg, count_next;
    logic                    do_push, do_pop;

    assign status.full  = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_item    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

### rtl/pfc_front.sv
// Front end: accepts payload beats and marks the first beat of each frame.
`default_nettype none

module pfc_front
    import pfc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    pfc_in_if.sink                in_ch,
    input  wire pfc_fifo_status_t fifo_status,
    output logic                  push,
    output pfc_item_t             push_item
);

    logic in_frame_reg, in_frame_next;

    assign in_ch.ready = !fifo_status.full;
    assign push        = in_ch.valid && !fifo_status.full;

    always_comb
    begin
        push_item.payload_byte = in_ch.payload_byte;
        push_item.frame_length = in_ch.frame_length;
        push_item.start        = !in_frame_reg;
        push_item.last         = in_ch.last_byte;
        in_frame_next          = push ? !in_ch.last_byte : in_frame_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_frame_reg <= 1'b0;
        else
            in_frame_reg <= in_frame_next;
    end

endmodule

`default_nettype wire

### rtl/pfc_back.sv
// Back end: expands queued beats into preamble, header, payload and CRC bytes.
`default_nettype none

module pfc_back
    import pfc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire pfc_item_t        head_item,
    input  wire pfc_fifo_status_t fifo_status,
    output logic                  pop,
    pfc_out_if.source             out_ch
);

    pfc_phase_t             phase_reg, phase_next, cur_phase;
    logic [PRE_CNT_W-1:0]   pre_cnt_reg, pre_cnt_next;
    logic [31:0]            crc_reg, crc_next, crc_fin;
    logic                   out_valid_reg, out_valid_next;
    logic [7:0]             out_byte_reg, out_byte_next;
    logic                   out_eof_reg, out_eof_next;
    logic                   out_eob_reg, out_eob_next;
    logic                   load_ok, advance;

    assign load_ok = !out_valid_reg || out_ch.ready;
    assign advance = !fifo_status.empty && load_ok;
    assign crc_fin = ~crc_reg;

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.out_byte     = out_byte_reg;
    assign out_ch.end_of_frame = out_eof_reg;
    assign out_ch.end_of_burst = out_eob_reg;

    always_comb
    begin
        if (phase_reg == PH_HEAD)
            cur_phase = head_item.start ? PH_PRE : PH_DATA;
        else
            cur_phase = phase_reg;

        phase_next     = phase_reg;
        pre_cnt_next   = pre_cnt_reg;
        crc_next       = crc_reg;
        pop            = 1'b0;
        out_byte_next  = out_byte_reg;
        out_eof_next   = out_eof_reg;
        out_eob_next   = out_eob_reg;
        out_valid_next = out_ch.ready ? 1'b0 : out_valid_reg;

        if (advance)
        begin
            out_valid_next = 1'b1;
            out_eof_next   = 1'b0;
            out_eob_next   = 1'b0;
            case (cur_phase)
                PH_PRE:
                begin
                    out_byte_next = PREAMBLE_BYTE;
                    if (pre_cnt_reg == PRE_CNT_W'(PRE_COUNT - 1))
                    begin
                        pre_cnt_next = '0;
                        phase_next   = PH_LEN;
                    end
                    else
                    begin
                        pre_cnt_next = pre_cnt_reg + 1'b1;
                        phase_next   = PH_PRE;
                    end
                end
                PH_LEN:
                begin
                    out_byte_next = head_item.frame_length;
                    phase_next    = PH_ZERO1;
                end
                PH_ZERO1:
                begin
                    out_byte_next = HEADER_ZERO;
                    phase_next    = PH_ZERO2;
                end
                PH_ZERO2:
                begin
                    out_byte_next = HEADER_ZERO;
                    phase_next    = PH_DATA;
                end
                PH_DATA:
                begin
                    out_byte_next = head_item.payload_byte;
                    crc_next      = crc_byte(head_item.start ? CRC_INIT : crc_reg,
                                             head_item.payload_byte);
                    if (head_item.last)
                        phase_next = PH_CRC3;
                    else
                    begin
                        out_eob_next = 1'b1;
                        pop          = 1'b1;
                        phase_next   = PH_HEAD;
                    end
                end
                PH_CRC3:
                begin
                    out_byte_next = crc_fin[31:24];
                    phase_next    = PH_CRC2;
                end
                PH_CRC2:
                begin
                    out_byte_next = crc_fin[23:16];
                    phase_next    = PH_CRC1;
                end
                PH_CRC1:
                begin
                    out_byte_next = crc_fin[15:8];
                    phase_next    = PH_CRC0;
                end
                PH_CRC0:
                begin
                    out_byte_next = crc_fin[7:0];
                    out_eof_next  = 1'b1;
                    out_eob_next  = 1'b1;
                    crc_next      = CRC_INIT;
                    pop           = 1'b1;
                    phase_next    = PH_HEAD;
                end
                default:
                begin
                    phase_next = PH_HEAD;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEAD;
            pre_cnt_reg   <= '0;
            crc_reg       <= CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pre_cnt_reg   <= pre_cnt_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_eof_reg  <= out_eof_next;
        out_eob_reg  <= out_eob_next;
    end

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the packet framer: framing, header and CRC-32 trailer.

typedef struct packed {
    logic [7:0] data;
    logic       eof;
    logic       eob;
} framed_beat_t;

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pfc_pkg::*;

    localparam int RANDOM_ITEMS   = 100;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 40;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int MAX_REPORTS    = 10;

    // Keeps the framed bytes that the accepted payload beats must produce, in order.
    class framer_scoreboard;
        framed_beat_t expected_q[$];
        logic [31:0]  crc_reg;
        bit           in_frame;
        int           burst_len;
        int           burst_pos;
        int           mismatches;
        int           beats_checked;
        int           payload_beats;
        int           frames_done;

        function new();
            crc_reg       = CRC_INIT;
            in_frame      = 1'b0;
            mismatches    = 0;
            beats_checked = 0;
            payload_beats = 0;
            frames_done   = 0;
        endfunction

        // Reflected CRC-32, least significant data bit first.
        function logic [31:0] crc32_update(logic [31:0] c, logic [7:0] d);
            logic fb;
            for (int i = 0; i < 8; i++)
            begin
                fb = c[0] ^ d[i];
                c  = c >> 1;
                if (fb)
                    c = c ^ CRC_POLY;
            end
            return c;
        endfunction

        function void queue_beat(logic [7:0] d, logic eof);
            framed_beat_t b;
            b.data = d;
            b.eof  = eof;
            b.eob  = (burst_pos == burst_len - 1);
            expected_q.push_back(b);
            burst_pos++;
        endfunction

        function void note_payload(logic [7:0] pb, logic [7:0] len, logic last);
            logic [31:0] fcs;
            burst_len = (in_frame ? 0 : PRE_COUNT + 3) + 1 + (last ? 4 : 0);
            burst_pos = 0;
            payload_beats++;
            if (!in_frame)
            begin
                for (int i = 0; i < PRE_COUNT; i++)
                    queue_beat(PREAMBLE_BYTE, 1'b0);
                queue_beat(len, 1'b0);
                queue_beat(HEADER_ZERO, 1'b0);
                queue_beat(HEADER_ZERO, 1'b0);
                crc_reg  = CRC_INIT;
                in_frame = 1'b1;
            end
            queue_beat(pb, 1'b0);
            crc_reg = crc32_update(crc_reg, pb);
            if (last)
            begin
                fcs = ~crc_reg;
                queue_beat(fcs[31:24], 1'b0);
                queue_beat(fcs[23:16], 1'b0);
                queue_beat(fcs[15:8], 1'b0);
                queue_beat(fcs[7:0], 1'b1);
                crc_reg  = CRC_INIT;
                in_frame = 1'b0;
                frames_done++;
            end
        endfunction

        function void check_beat(logic [7:0] d, logic eof, logic eob);
            framed_beat_t want;
            beats_checked++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR at %0t: unexpected beat data=%02h eof=%0b eob=%0b",
                             $time, d, eof, eob);
                return;
            end
            want = expected_q.pop_front();
            if (want.data !== d || want.eof !== eof || want.eob !== eob)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR at %0t: beat %0d expected data=%02h eof=%0b eob=%0b,",
                             $time, beats_checked, want.data, want.eof, want.eob,
                             " got data=%02h eof=%0b eob=%0b", d, eof, eob);
            end
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    pfc_in_if  in_ch();
    pfc_out_if out_ch();

    framer_scoreboard sb = new();

    bit send_fast = 1'b0;
    bit recv_fast = 1'b0;
    bit hold_req  = 1'b0;
    int cycles;

    packet_framer_crc32 i_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Both handshakes are seen in one place, input first, so a same-edge pass-through is safe.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                sb.note_payload(in_ch.payload_byte, in_ch.frame_length, in_ch.last_byte);
            if (out_ch.valid && out_ch.ready)
                sb.check_beat(out_ch.out_byte, out_ch.end_of_frame, out_ch.end_of_burst);
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < TIMEOUT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles with %0d framed bytes outstanding",
                 cycles, sb.expected_q.size());
        $display("*** FAILED ***");
        $finish;
    end

    // Output side: random stall before each beat, plus one long hold-off on request.
    initial
    begin : receiver
        int stall;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            stall = recv_fast ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                out_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge clk); while (!out_ch.valid);
            @(negedge clk);
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken,
    // with valid dropped unless the next call raises it again at once.
    task automatic drive_payload(input logic [7:0] pb, input logic [7:0] len, input logic last);
        int gap;
        gap = send_fast ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_ch.valid        = 1'b0;
            in_ch.payload_byte = 8'($urandom);
            in_ch.frame_length = 8'($urandom);
            in_ch.last_byte    = 1'($urandom);
            repeat (gap) @(negedge clk);
        end
        in_ch.payload_byte = pb;
        in_ch.frame_length = len;
        in_ch.last_byte    = last;
        in_ch.valid        = 1'b1;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
        in_ch.valid = 1'b0;
    endtask

    // The length field matters only on the opening byte; later bytes carry noise there.
    task automatic send_frame(input int count, input logic [7:0] len);
        for (int i = 0; i < count; i++)
            drive_payload(8'($urandom), (i == 0) ? len : 8'($urandom), i == count - 1);
    endtask

    task automatic wait_idle();
        while (sb.expected_q.size() > 0)
            @(negedge clk);
    endtask

    initial
    begin : stimulus
        int items;
        int count;
        logic [7:0] len;

        in_ch.valid        = 1'b0;
        in_ch.payload_byte = 8'd0;
        in_ch.frame_length = 8'd0;
        in_ch.last_byte    = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Frames of one to three bytes at field extremes, with zero and mismatched lengths.
        drive_payload(8'h00, 8'd1, 1'b1);
        drive_payload(8'hFF, 8'd255, 1'b1);
        drive_payload(8'hA5, 8'd0, 1'b1);
        drive_payload(8'h00, 8'd3, 1'b0);
        drive_payload(8'hFF, 8'hFF, 1'b0);
        drive_payload(8'h55, 8'h00, 1'b1);
        drive_payload(8'h80, 8'd200, 1'b0);
        drive_payload(8'h01, 8'h7F, 1'b1);
        // The usual check string "123456789" gives a CRC-32 of CBF43926.
        for (int i = 0; i < 9; i++)
            drive_payload(8'h31 + 8'(i), 8'd9, i == 8);

        // Back to back on both sides.
        send_fast = 1'b1;
        recv_fast = 1'b1;
        send_frame(6, 8'd6);
        send_frame(1, 8'd1);
        send_frame(4, 8'd4);
        recv_fast = 1'b0;

        // The receiver holds off while the sender keeps offering, so input backs up.
        wait_idle();
        hold_req = 1'b1;
        send_frame(24, 8'd24);
        send_fast = 1'b0;
        wait_idle();

        items = 0;
        while (items < RANDOM_ITEMS)
        begin
            count = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 10);
            len   = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'(count);
            send_fast = ($urandom_range(0, 4) == 0);
            recv_fast = ($urandom_range(0, 4) == 0);
            send_frame(count, len);
            items += count;
        end
        in_ch.valid = 1'b0;
        send_fast   = 1'b0;
        recv_fast   = 1'b0;

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d frames from %0d payload beats; %0d framed bytes checked.",
                 sb.frames_done, sb.payload_beats, sb.beats_checked);
        $display("Frames included single-byte, zero-length, mismatched-length %s",
                 "and backpressured cases.");
        if (sb.expected_q.size() > 0)
            $display("ERROR: %0d framed bytes never arrived", sb.expected_q.size());
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("*** PASSED ***");
        else
        begin
            $display("%0d mismatching beats in total", sb.mismatches);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### sim.f
rtl/pfc_pkg.sv
rtl/pfc_in_if.sv
rtl/pfc_out_if.sv
rtl/pfc_fifo.sv
rtl/pfc_front.sv
rtl/pfc_back.sv
rtl/packet_framer_crc32.sv
tb/tb_top.sv
